>>> hdl/fps_pkg.sv
// Shared types and constants of the frame pixel statistics block.
// No dependencies; every other file refers to it by scoped names.
package fps_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned RUN_W      = 9;
  localparam int unsigned ROWS_W     = 9;
  localparam int unsigned CNT_W      = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned AW_W       = 10;
  localparam int unsigned AH_W       = 9;

  localparam int unsigned WIDTH_RST  = 320;
  localparam int unsigned HEIGHT_RST = 200;
  localparam logic [PIX_W-1:0] THR_RST = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [RUN_W-1:0] RUN_MAX = 9'd511;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH       = 2'd0,
    CFG_ACTIVE_HEIGHT      = 2'd1,
    CFG_CONTRAST_THRESHOLD = 2'd2
  } cfg_idx_e;

  // Position flags of one pixel, produced when it is accepted.
  typedef struct packed {
    logic have_up;
    logic col_nz;
    logic row_end;
    logic last_row;
    logic frame_end;
    logic mirror_chk;
  } issue_t;

  // One column entry: contrast still pending for the pixel, and its run.
  typedef struct packed {
    logic             pending;
    logic [RUN_W-1:0] run;
  } col_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]  max_value;
    logic [PIX_W-1:0]  min_value;
    logic [ROWS_W-1:0] asymmetric_rows;
    logic [CNT_W-1:0]  contrast_pixels;
    logic [RUN_W-1:0]  longest_vertical_run;
  } result_t;

endpackage

>>> hdl/fps_if.sv
// Stream interfaces of the frame pixel statistics block: pixel in, result out.
// Depends on fps_pkg for the field widths.
interface fps_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [fps_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface fps_result_if;
  logic                      valid;
  logic                      ready;
  logic [fps_pkg::PIX_W-1:0]  max_value;
  logic [fps_pkg::PIX_W-1:0]  min_value;
  logic [fps_pkg::ROWS_W-1:0] asymmetric_rows;
  logic [fps_pkg::CNT_W-1:0]  contrast_pixels;
  logic [fps_pkg::RUN_W-1:0]  longest_vertical_run;

  modport source (output valid, output max_value, output min_value,
                  output asymmetric_rows, output contrast_pixels,
                  output longest_vertical_run, input ready);
  modport sink (input valid, input max_value, input min_value,
                input asymmetric_rows, input contrast_pixels,
                input longest_vertical_run, output ready);
endinterface

>>> hdl/fps_cfg.sv
// Configuration registers; width and height are stored clamped, minus one.
// Depends on fps_pkg.
module fps_cfg #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [fps_pkg::CFG_IDX_W-1:0]   index_i,
  input  logic [fps_pkg::CFG_DATA_W-1:0]  data_i,
  output logic [fps_pkg::PIX_W-1:0]       thr_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    wm1_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]   hm1_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam logic [XW-1:0] WM1_RST = XW'(((fps_pkg::WIDTH_RST > MAX_WIDTH) ?
                                           MAX_WIDTH : fps_pkg::WIDTH_RST) - 1);
  localparam logic [YW-1:0] HM1_RST = YW'(((fps_pkg::HEIGHT_RST > MAX_HEIGHT) ?
                                           MAX_HEIGHT : fps_pkg::HEIGHT_RST) - 1);

  logic [31:0]   raw_w, raw_h;
  logic [XW-1:0] wm1_d, wm1_q;
  logic [YW-1:0] hm1_d, hm1_q;
  logic [fps_pkg::PIX_W-1:0] thr_q;

  // A size of zero acts as one, a size above the maximum as the maximum.
  always_comb begin
    raw_w = 32'(data_i[fps_pkg::AW_W-1:0]);
    raw_h = 32'(data_i[fps_pkg::AH_W-1:0]);
    if (raw_w == 32'd0) begin
      wm1_d = '0;
    end else if (raw_w > 32'(MAX_WIDTH)) begin
      wm1_d = XW'(MAX_WIDTH - 1);
    end else begin
      wm1_d = XW'(raw_w - 32'd1);
    end
    if (raw_h == 32'd0) begin
      hm1_d = '0;
    end else if (raw_h > 32'(MAX_HEIGHT)) begin
      hm1_d = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1_d = YW'(raw_h - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= WM1_RST;
      hm1_q <= HM1_RST;
      thr_q <= fps_pkg::THR_RST;
    end else if (we_i) begin
      unique case (fps_pkg::cfg_idx_e'(index_i))
        fps_pkg::CFG_ACTIVE_WIDTH:       wm1_q <= wm1_d;
        fps_pkg::CFG_ACTIVE_HEIGHT:      hm1_q <= hm1_d;
        fps_pkg::CFG_CONTRAST_THRESHOLD: thr_q <= data_i[fps_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign thr_o = thr_q;
  assign wm1_o = wm1_q;
  assign hm1_o = hm1_q;

endmodule

>>> hdl/fps_sequencer.sv
// Raster position counters; derives read addresses and position flags
// of the pixel being accepted. Depends on fps_pkg.
module fps_sequencer #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wm1_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] hm1_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_x_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_m_o,
  output fps_pkg::issue_t               ctrl_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  logic [XW-1:0] col_d, col_q;
  logic [YW-1:0] row_d, row_q;
  logic          row_end, last_row;

  always_comb begin
    row_end  = col_q >= wm1_i;
    last_row = row_q >= hm1_i;

    ctrl_o.have_up    = row_q != '0;
    ctrl_o.col_nz     = col_q != '0;
    ctrl_o.row_end    = row_end;
    ctrl_o.last_row   = last_row;
    ctrl_o.frame_end  = row_end && last_row;
    // Right half of the row: compare against the mirrored left pixel.
    ctrl_o.mirror_chk = (col_q <= wm1_i) && ({col_q, 1'b0} > {1'b0, wm1_i});

    rd_x_o = col_q;
    rd_m_o = wm1_i - col_q;

    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + YW'(1);
      end else begin
        col_d = col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> hdl/fps_datapath.sv
// Line memories and per-frame statistics: reads issued at accept, results
// in the cycle after, write-back with forwarding. Depends on fps_pkg.
module fps_datapath #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_x_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_m_i,
  input  fps_pkg::issue_t              ctrl_i,
  input  logic [fps_pkg::PIX_W-1:0]    pixel_i,
  input  logic [fps_pkg::PIX_W-1:0]    thr_i,
  output logic                         push_o,
  output fps_pkg::result_t             result_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = fps_pkg::PIX_W;
  localparam int unsigned RW = fps_pkg::RUN_W;
  localparam int unsigned CW = fps_pkg::CNT_W;
  localparam int unsigned MW = fps_pkg::ROWS_W;

  function automatic logic [PW-1:0] abs_diff(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [PW-1:0]      pix_mem [MAX_WIDTH];
  fps_pkg::col_word_t col_mem [MAX_WIDTH];

  // Second stage registers.
  logic               b_valid_q;
  fps_pkg::issue_t    b_ctrl_q;
  logic [XW-1:0]      b_x_q;
  logic [PW-1:0]      b_p_q;
  logic [PW-1:0]      above_rd_q, mirror_rd_q;
  fps_pkg::col_word_t col_rd_q;
  logic               above_hit_d, above_hit_q, mirror_hit_d, mirror_hit_q;
  logic [PW-1:0]      fwd_pix_q;
  logic               col_hit_d, col_hit_q;
  fps_pkg::col_word_t col_fwd_d, col_fwd_q;

  // Previous pixel of the row and the deferred write of a row's last entry.
  logic [PW-1:0]      left_pix_q;
  logic               left_pend_q;
  logic [RW-1:0]      left_run_q;
  logic               tail_v_q;
  logic [XW-1:0]      tail_x_q;
  fps_pkg::col_word_t tail_q;

  logic [PW-1:0]      max_q, min_q, max_new, min_new;
  logic               row_mm_q, row_mm;
  logic [MW-1:0]      mm_cnt_q, mm_cnt_new;
  logic [CW-1:0]      cnt_q, cnt_new;
  logic [CW:0]        cnt_sum;
  logic [RW-1:0]      best_q, best_new;

  logic [PW-1:0]      above, mirror_px;
  fps_pkg::col_word_t col_up, col_wdata, tail_word;
  logic               dl, du, lf, cur, mm;
  logic               inc_up, inc_left, inc_cur;
  logic [1:0]         n_inc;
  logic [RW-1:0]      run_cur;
  logic               col_we, new_tail;
  logic [XW-1:0]      col_waddr;

  always_comb begin
    above     = above_hit_q ? fwd_pix_q : above_rd_q;
    mirror_px = mirror_hit_q ? fwd_pix_q : mirror_rd_q;
    col_up    = col_hit_q ? col_fwd_q : col_rd_q;

    dl  = b_ctrl_q.col_nz && (abs_diff(b_p_q, left_pix_q) > thr_i);
    du  = b_ctrl_q.have_up && (abs_diff(b_p_q, above) > thr_i);
    lf  = left_pend_q || dl;
    cur = dl || du;
    mm  = b_ctrl_q.mirror_chk && (mirror_px != b_p_q);

    // The pixel above is complete once this pixel is known; on the last row, so
    // are the left pixel and, at row end, this pixel.
    inc_up   = b_ctrl_q.have_up && (col_up.pending || du);
    inc_left = b_ctrl_q.last_row && b_ctrl_q.col_nz && lf;
    inc_cur  = b_ctrl_q.last_row && b_ctrl_q.row_end && cur;
    n_inc    = {1'b0, inc_up} + {1'b0, inc_left} + {1'b0, inc_cur};
    cnt_sum  = {1'b0, cnt_q} + (CW + 1)'(n_inc);
    cnt_new  = cnt_sum[CW] ? '1 : cnt_sum[CW-1:0];

    if (b_ctrl_q.have_up && (above == b_p_q)) begin
      run_cur = (col_up.run == fps_pkg::RUN_MAX) ? fps_pkg::RUN_MAX :
                col_up.run + RW'(1);
    end else begin
      run_cur = RW'(1);
    end

    max_new  = (b_p_q > max_q) ? b_p_q : max_q;
    min_new  = (b_p_q < min_q) ? b_p_q : min_q;
    best_new = (run_cur > best_q) ? run_cur : best_q;
    row_mm   = row_mm_q || mm;
    mm_cnt_new = (b_ctrl_q.row_end && row_mm && (mm_cnt_q != '1)) ?
                 mm_cnt_q + MW'(1) : mm_cnt_q;

    // Column entries trail by one pixel; the row's last entry goes out in
    // the next cycle, when the following pixel (column zero) writes nothing.
    tail_word.pending = cur;
    tail_word.run     = run_cur;
    new_tail          = b_valid_q && b_ctrl_q.row_end;
    if (b_valid_q && b_ctrl_q.col_nz) begin
      col_we            = 1'b1;
      col_waddr         = b_x_q - XW'(1);
      col_wdata.pending = lf;
      col_wdata.run     = left_run_q;
    end else begin
      col_we    = tail_v_q;
      col_waddr = tail_x_q;
      col_wdata = tail_q;
    end

    // Forwarding toward the read issued in this cycle, newest first.
    above_hit_d  = b_valid_q && (b_x_q == rd_x_i);
    mirror_hit_d = b_valid_q && (b_x_q == rd_m_i);
    if (new_tail && (b_x_q == rd_x_i)) begin
      col_hit_d = 1'b1;
      col_fwd_d = tail_word;
    end else if (col_we && (col_waddr == rd_x_i)) begin
      col_hit_d = 1'b1;
      col_fwd_d = col_wdata;
    end else begin
      col_hit_d = 1'b0;
      col_fwd_d = col_wdata;
    end

    push_o                        = b_valid_q && b_ctrl_q.frame_end;
    result_o.max_value            = max_new;
    result_o.min_value            = min_new;
    result_o.asymmetric_rows      = mm_cnt_new;
    result_o.contrast_pixels      = cnt_new;
    result_o.longest_vertical_run = best_new;
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      pix_mem[b_x_q] <= b_p_q;
    end
    above_rd_q  <= pix_mem[rd_x_i];
    mirror_rd_q <= pix_mem[rd_m_i];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rd_q <= col_mem[rd_x_i];
  end

  always_ff @(posedge clk_i) begin
    b_ctrl_q     <= ctrl_i;
    b_x_q        <= rd_x_i;
    b_p_q        <= pixel_i;
    above_hit_q  <= above_hit_d;
    mirror_hit_q <= mirror_hit_d;
    fwd_pix_q    <= b_p_q;
    col_hit_q    <= col_hit_d;
    col_fwd_q    <= col_fwd_d;
    if (new_tail) begin
      tail_x_q <= b_x_q;
      tail_q   <= tail_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      tail_v_q    <= 1'b0;
      left_pix_q  <= '0;
      left_pend_q <= 1'b0;
      left_run_q  <= '0;
      max_q       <= '0;
      min_q       <= fps_pkg::PIX_MAX;
      row_mm_q    <= 1'b0;
      mm_cnt_q    <= '0;
      cnt_q       <= '0;
      best_q      <= '0;
    end else begin
      b_valid_q <= rd_en_i;
      tail_v_q  <= new_tail;
      if (b_valid_q) begin
        left_pix_q  <= b_p_q;
        left_pend_q <= cur;
        left_run_q  <= run_cur;
        if (b_ctrl_q.frame_end) begin
          max_q    <= '0;
          min_q    <= fps_pkg::PIX_MAX;
          row_mm_q <= 1'b0;
          mm_cnt_q <= '0;
          cnt_q    <= '0;
          best_q   <= '0;
        end else begin
          max_q    <= max_new;
          min_q    <= min_new;
          row_mm_q <= b_ctrl_q.row_end ? 1'b0 : row_mm;
          mm_cnt_q <= mm_cnt_new;
          cnt_q    <= cnt_new;
          best_q   <= best_new;
        end
      end
    end
  end

  a_col_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_ctrl_q.col_nz) |-> !tail_v_q)
    else $error("column write of a pixel collides with a deferred row-end write");

  a_tail_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_v_q |-> $past(b_valid_q && b_ctrl_q.row_end))
    else $error("deferred row-end write not issued in the following cycle");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_ctrl_q.frame_end) |=>
      (cnt_q == '0) && (best_q == '0) && (mm_cnt_q == '0))
    else $error("frame statistics not cleared after the frame's last pixel");

endmodule

>>> hdl/fps_result_buf.sv
// Two-entry result buffer (output register plus skid register) driving the
// result channel. Depends on fps_pkg and fps_if.
module fps_result_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fps_pkg::result_t    data_i,
  output logic                room_o,
  fps_result_if.source        res_o
);

  logic             main_v_d, main_v_q, skid_v_d, skid_v_q;
  fps_pkg::result_t main_d, main_q, skid_d, skid_q;
  logic             pop;

  always_comb begin
    pop      = main_v_q && res_o.ready;
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = push_i;
        skid_d   = data_i;
      end else begin
        main_v_d = push_i;
        main_d   = data_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_v_d = 1'b1;
        skid_d   = data_i;
      end else begin
        main_v_d = 1'b1;
        main_d   = data_i;
      end
    end
    // A pixel accepted now may end a frame in the next cycle, so leave a slot.
    // A leaving output entry frees its slot at once if the skid is empty.
    room_o = !(skid_v_q || (main_v_q && push_i && !pop));
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  assign res_o.valid                = main_v_q;
  assign res_o.max_value            = main_q.max_value;
  assign res_o.min_value            = main_q.min_value;
  assign res_o.asymmetric_rows      = main_q.asymmetric_rows;
  assign res_o.contrast_pixels      = main_q.contrast_pixels;
  assign res_o.longest_vertical_run = main_q.longest_vertical_run;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without an output entry");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !push_i)
    else $error("result pushed into a full buffer");

  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room_o |-> res_o.valid)
    else $error("input held off while no result waits");

endmodule

>>> hdl/frame_pixel_statistics_core.sv
// Top level of the frame pixel statistics block.
// Depends on fps_pkg, fps_if, fps_cfg, fps_sequencer, fps_datapath, fps_result_buf.
//
// Usage:
//   Pixels enter on pixel_i in raster order, one item per accepted handshake.
//   At the last pixel of a frame (active_width x active_height) one result
//   item leaves on result_o, through the second datapath stage and the
//   result buffer. Throughput is one pixel per clock while pixel_i.ready is
//   high. The limit is the line memories: each pixel reads its column (pixel
//   above, mirror pixel, run and pending contrast) in the accept cycle and writes
//   them back from the second stage, with forwarding between neighboring pixels.
//   A two-entry result buffer parts the result channel from the pixel
//   channel: while the receiver stalls, pixels of the next frame keep
//   flowing, and pixel_i.ready drops only while two results wait, or while
//   one waits that the receiver does not take and another frame is about
//   to end.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i;
//   the user must write it only while no pixel is in flight, which the block
//   itself does not enforce; width and height out of range are clamped.
//   Reset puts the registers at 320 x 200 with threshold 128 and starts a new
//   frame. The line memories need no clearing: row zero uses only entries it wrote.
module frame_pixel_statistics_core #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fps_pixel_if.sink                      pixel_i,
  fps_result_if.source                   result_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  logic [fps_pkg::PIX_W-1:0] thr;
  logic [XW-1:0]             wm1, rd_x, rd_m;
  logic [YW-1:0]             hm1;
  fps_pkg::issue_t           ctrl;
  fps_pkg::result_t          result;
  logic                      accept, push, room;

  // An item is taken only when the result buffer can absorb a frame end.
  assign pixel_i.ready = room;
  assign accept        = pixel_i.valid && room;

  fps_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .thr_o   (thr),
    .wm1_o   (wm1),
    .hm1_o   (hm1)
  );

  // Position of the pixel being accepted and the addresses it reads.
  fps_sequencer #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .wm1_i    (wm1),
    .hm1_i    (hm1),
    .rd_x_o   (rd_x),
    .rd_m_o   (rd_m),
    .ctrl_o   (ctrl)
  );

  // Memory read in the accept cycle, statistics and write-back in the second stage.
  fps_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_x_i   (rd_x),
    .rd_m_i   (rd_m),
    .ctrl_i   (ctrl),
    .pixel_i  (pixel_i.pixel),
    .thr_i    (thr),
    .push_o   (push),
    .result_o (result)
  );

  fps_result_buf u_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (result),
    .room_o (room),
    .res_o  (result_o)
  );

endmodule

>>> sim/frame_pixel_statistics_core_test.sv
// Self-checking testbench of frame_pixel_statistics_core: it streams frames of
// random and hand-picked pixels and checks every result against its own model.
// Depends on fps_pkg, fps_if and the RTL of the block; nothing else is read.
module frame_pixel_statistics_core_test;

  localparam int unsigned MAX_W          = 512;
  localparam int unsigned MAX_H          = 256;
  localparam int unsigned RUN_SAT        = 511;
  localparam int unsigned ROWS_SAT       = 511;
  localparam int unsigned CONTRAST_SAT   = 262143;
  // Idle margin after the last result, before new settings or the run's end.
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned RANDOM_PIXELS  = 220;
  localparam int unsigned RUN_LIMIT      = 4_000_000;
  // Index 3 decodes to no register; a write there must change nothing.
  localparam logic [fps_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef enum int unsigned {
    FILL_UNIFORM,
    FILL_TWO_LEVEL,
    FILL_MIRROR,
    FILL_COLUMN
  } fill_e;

  // Tracks the frame statistics the block should produce. Every accepted
  // pixel goes through add_pixel, which keeps its own copy of the line stores
  // and per-frame counters and queues one expected result at each frame end.
  class frame_stats_tracker;
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned thr_reg;

    bit [7:0] line_mem [MAX_W];
    bit       pend_mem [MAX_W];
    bit [8:0] run_mem  [MAX_W];

    int unsigned col, row, left_pix;
    bit          left_pend;
    int unsigned hi, lo;
    bit          row_asym;
    int unsigned asym_rows, contrast_cnt, best;

    fps_pkg::result_t frame_stats_q [$];
    int unsigned mismatches;
    int unsigned frames_checked;

    function new();
      width_reg  = fps_pkg::WIDTH_RST;
      height_reg = fps_pkg::HEIGHT_RST;
      thr_reg    = 32'(fps_pkg::THR_RST);
      for (int i = 0; i < MAX_W; i++) begin
        line_mem[i] = '0;
        pend_mem[i] = 1'b0;
        run_mem[i]  = '0;
      end
      mismatches     = 0;
      frames_checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col          = 0;
      row          = 0;
      left_pix     = 0;
      left_pend    = 1'b0;
      hi           = 0;
      lo           = 255;
      row_asym     = 1'b0;
      asym_rows    = 0;
      contrast_cnt = 0;
      best         = 0;
    endfunction

    function void set_reg(logic [fps_pkg::CFG_IDX_W-1:0] idx,
                          logic [fps_pkg::CFG_DATA_W-1:0] data);
      if (idx == fps_pkg::CFG_ACTIVE_WIDTH) begin
        width_reg = 32'(data);
      end else if (idx == fps_pkg::CFG_ACTIVE_HEIGHT) begin
        height_reg = 32'(data[fps_pkg::AH_W-1:0]);
      end else if (idx == fps_pkg::CFG_CONTRAST_THRESHOLD) begin
        thr_reg = 32'(data[fps_pkg::PIX_W-1:0]);
      end
    endfunction

    // Sizes as the block applies them: zero acts as one, larger ones clamp.
    function int unsigned eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function int unsigned pending();
      return frame_stats_q.size();
    endfunction

    function int unsigned diff(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void bump_contrast();
      if (contrast_cnt < CONTRAST_SAT) contrast_cnt++;
    endfunction

    function void add_pixel(logic [7:0] pix);
      int unsigned w, h, x, y, p, above, run, m;
      bit have_up, dl, du, cur, last_row, lf;
      fps_pkg::result_t r;
      w = eff_width();
      h = eff_height();
      x = (col < MAX_W) ? col : MAX_W - 1;
      y = row;
      p = 32'(pix);

      if (p > hi) hi = p;
      if (p < lo) lo = p;

      have_up = (y > 0);
      above   = 32'(line_mem[x]);
      dl = (x > 0) && (diff(p, left_pix) > thr_reg);
      du = have_up && (diff(p, above) > thr_reg);

      // The pixel above now has all four neighbors known.
      if (have_up && (pend_mem[x] || du)) bump_contrast();

      run = 1;
      if (have_up && above == p) begin
        run = 32'(run_mem[x]) + 1;
        if (run > RUN_SAT) run = RUN_SAT;
      end
      run_mem[x] = 9'(run);
      if (run > best) best = run;

      // Right half of the row: compare with the mirrored pixel of this row.
      if (x <= w - 1 && 2 * x > w - 1) begin
        m = w - 1 - x;
        if (32'(line_mem[m]) != p) row_asym = 1'b1;
      end

      last_row = (y >= h - 1);

      if (x > 0) begin
        lf = left_pend || dl;
        pend_mem[x - 1] = lf;
        if (last_row && lf) bump_contrast();
      end

      cur = dl || du;
      line_mem[x] = 8'(p);

      if (x >= w - 1) begin
        pend_mem[x] = cur;
        if (last_row && cur) bump_contrast();
        if (row_asym && asym_rows < ROWS_SAT) asym_rows++;
        row_asym  = 1'b0;
        col       = 0;
        left_pix  = 0;
        left_pend = 1'b0;
        if (last_row) begin
          r.max_value            = 8'(hi);
          r.min_value            = 8'(lo);
          r.asymmetric_rows      = 9'(asym_rows);
          r.contrast_pixels      = 18'(contrast_cnt);
          r.longest_vertical_run = 9'(best);
          frame_stats_q.push_back(r);
          clear_frame();
        end else begin
          row++;
        end
      end else begin
        col       = x + 1;
        left_pix  = p;
        left_pend = cur;
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch in frame %0d, %s: got %0d, expected %0d",
               frames_checked, what, got, want);
      mismatches++;
    endtask

    task check_stats(fps_pkg::result_t got);
      fps_pkg::result_t want;
      if (frame_stats_q.size() == 0) begin
        report("result with no frame pending", 1, 0);
        return;
      end
      want = frame_stats_q.pop_front();
      if (got.max_value != want.max_value)
        report("max_value", 32'(got.max_value), 32'(want.max_value));
      if (got.min_value != want.min_value)
        report("min_value", 32'(got.min_value), 32'(want.min_value));
      if (got.asymmetric_rows != want.asymmetric_rows)
        report("asymmetric_rows", 32'(got.asymmetric_rows),
               32'(want.asymmetric_rows));
      if (got.contrast_pixels != want.contrast_pixels)
        report("contrast_pixels", 32'(got.contrast_pixels),
               32'(want.contrast_pixels));
      if (got.longest_vertical_run != want.longest_vertical_run)
        report("longest_vertical_run", 32'(got.longest_vertical_run),
               32'(want.longest_vertical_run));
      frames_checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we;
  logic [fps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fps_pkg::CFG_DATA_W-1:0] cfg_data;

  fps_pixel_if  pix_if ();
  fps_result_if res_if ();

  frame_pixel_statistics_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pixel_i     (pix_if),
    .result_o    (res_if)
  );

  frame_stats_tracker sb = new();

  // Pixels of the frame about to be sent, in raster order.
  bit [7:0] frame_pix [$];

  // Idling switches, chosen per frame so that some frames run without gaps.
  bit src_idle;
  bit sink_idle;
  // Set by the stimulus to start the receiver's long hold-off, sized by LONG_HOLD.
  bit hold_req;

  int unsigned pixels_sent;
  int unsigned frames_sent;
  int unsigned settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap(bit enable);
    int unsigned roll;
    if (!enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one pixel and holds it until the block takes it. The caller is
  // always at a rising edge, so valid is raised in the step after the
  // previous item, or after a gap in which it was low.
  task automatic send_pixel(logic [7:0] value);
    int unsigned gap;
    pix_if.valid <= 1'b1;
    pix_if.pixel <= value;
    do @(posedge clk_i); while (!pix_if.ready);
    sb.add_pixel(value);
    pixels_sent++;
    gap = pick_gap(src_idle);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_frame();
    foreach (frame_pix[i]) send_pixel(frame_pix[i]);
    frames_sent++;
  endtask

  // One register write per edge; the enable stays high across a burst of
  // writes and drops in the step after the last one.
  task automatic write_reg(logic [fps_pkg::CFG_IDX_W-1:0] idx,
                           logic [fps_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // Registers change only between frames. The valid line is low here unless
  // the last item was taken without a gap, so it is lowered first, and every
  // result must have left the block before the new geometry goes in.
  task automatic configure(logic [fps_pkg::CFG_DATA_W-1:0] w,
                           logic [fps_pkg::CFG_DATA_W-1:0] h,
                           logic [fps_pkg::CFG_DATA_W-1:0] thr,
                           bit with_thr);
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(fps_pkg::CFG_ACTIVE_WIDTH, w);
    write_reg(fps_pkg::CFG_ACTIVE_HEIGHT, h);
    if (with_thr) write_reg(fps_pkg::CFG_CONTRAST_THRESHOLD, thr);
    write_reg(CFG_SPARE_IDX, 10'($urandom_range(0, 1023)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Builds a frame of the current geometry and sends it. Mirror fills copy most
  // right-half pixels from the left half, column fills make long vertical runs,
  // and two-level fills give sharp edges whose contrast depends on the threshold.
  task automatic random_frame(fill_e mode);
    int unsigned w, h, idx, x, y;
    bit [7:0] v, lvl_a, lvl_b;
    w     = sb.eff_width();
    h     = sb.eff_height();
    lvl_a = 8'($urandom_range(0, 255));
    lvl_b = 8'($urandom_range(0, 255));
    frame_pix.delete();
    for (idx = 0; idx < w * h; idx++) begin
      x = idx % w;
      y = idx / w;
      case (mode)
        FILL_UNIFORM: begin
          v = 8'($urandom_range(0, 255));
        end
        FILL_TWO_LEVEL: begin
          v = $urandom_range(0, 1) ? lvl_a : lvl_b;
        end
        FILL_MIRROR: begin
          if (2 * x > w - 1 && $urandom_range(0, 7) != 0) begin
            v = frame_pix[y * w + (w - 1 - x)];
          end else if ($urandom_range(0, 3) == 0) begin
            v = 8'($urandom_range(0, 255));
          end else begin
            v = $urandom_range(0, 1) ? lvl_a : lvl_b;
          end
        end
        default: begin
          if (y > 0 && $urandom_range(0, 3) != 0) v = frame_pix[idx - w];
          else v = 8'($urandom_range(0, 255));
        end
      endcase
      frame_pix.push_back(v);
    end
    send_frame();
  endtask

  // Result side: checks each item taken at an edge, then decides whether to
  // be ready at the next one. A hold request from the stimulus overrides the
  // usual short stalls with one long stretch counted here.
  initial begin
    int unsigned stall_left;
    fps_pkg::result_t got;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got.max_value            = res_if.max_value;
        got.min_value            = res_if.min_value;
        got.asymmetric_rows      = res_if.asymmetric_rows;
        got.contrast_pixels      = res_if.contrast_pixels;
        got.longest_vertical_run = res_if.longest_vertical_run;
        sb.check_stats(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (sink_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b1);
      end
    end
  end

  // Stimulus: a short directed part, a pressure phase, the largest sizes,
  // then random frames of mostly small sizes until the pixel budget is used.
  initial begin
    int unsigned start_count, w, h, thr, frames;
    rst_ni        = 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= fps_pkg::CFG_ACTIVE_WIDTH;
    cfg_data     <= '0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    hold_req      = 1'b0;
    pixels_sent   = 0;
    frames_sent   = 0;
    settings_used = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x2 with the threshold left at its reset value: the extreme pixel
    // levels, one symmetric row and one asymmetric row.
    configure(3, 2, 0, 1'b0);
    frame_pix = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd127};
    send_frame();

    // Zero width and height act as one: single-pixel frames.
    configure(0, 0, 0, 1'b1);
    frame_pix = '{8'd255};
    send_frame();
    frame_pix = '{8'd0};
    send_frame();

    // One column with the highest threshold: a vertical run, no contrast.
    configure(1, 4, 255, 1'b1);
    frame_pix = '{8'd7, 8'd7, 8'd7, 8'd200};
    send_frame();

    // Zero threshold: every differing neighbor counts.
    configure(4, 2, 0, 1'b1);
    frame_pix = '{8'd1, 8'd2, 8'd2, 8'd1, 8'd1, 8'd2, 8'd3, 8'd1};
    send_frame();

    // A full-scale step just above a threshold of 254.
    configure(2, 1, 254, 1'b1);
    frame_pix = '{8'd0, 8'd255};
    send_frame();

    // Tiny frames against a long receiver hold-off: the result buffer fills
    // and the block has to stall its pixel input.
    configure(2, 1, 60, 1'b1);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 1'b1;
    repeat (12) random_frame(FILL_UNIFORM);

    // Sizes above the limits clamp: a full-width row, then a full-height
    // frame of one level so that its column runs from top to bottom.
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    configure(10'h3FF, 1, 40, 1'b1);
    random_frame(FILL_MIRROR);
    configure(1, 10'h3FF, 255, 1'b1);
    frame_pix.delete();
    repeat (MAX_H) frame_pix.push_back(8'd90);
    send_frame();

    start_count = pixels_sent;
    while (pixels_sent < start_count + RANDOM_PIXELS) begin
      w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      if ($urandom_range(0, 15) == 0) w = 0;
      h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      configure(10'(w), 10'(h), 10'(thr), 1'b1);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        src_idle  = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
        random_frame(fill_e'($urandom_range(0, 3)));
      end
    end

    pix_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels in %0d frames over %0d register settings, %0d results checked,",
             pixels_sent, frames_sent, settings_used, sb.frames_checked);
    $display("from single-pixel frames up to clamped 512-wide and 256-tall ones.");
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    #(RUN_LIMIT);
    $display("Timed out with %0d results still outstanding.", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> frame_pixel_statistics_core.f
hdl/fps_pkg.sv
hdl/fps_if.sv
hdl/fps_cfg.sv
hdl/fps_sequencer.sv
hdl/fps_datapath.sv
hdl/fps_result_buf.sv
hdl/frame_pixel_statistics_core.sv
sim/frame_pixel_statistics_core_test.sv
